>>> hdl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon ray-cast classifier.
// ----------------------------------------------------------------------------
`default_nettype none
package pip_pkg;
	localparam int COORD_BITS_DEF = 24;
	localparam int AREA_TOL_BITS  = 40;
	localparam int LEVEL_TOL_BITS = 23;
	localparam int CFG_BITS       = 40;
	localparam int CFG_IDX_BITS   = 1;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_AREA_TOL  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_TOL = 1'b1;

	localparam logic [1:0] POS_INSIDE   = 2'd0;
	localparam logic [1:0] POS_BOUNDARY = 2'd1;
	localparam logic [1:0] POS_OUTSIDE  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ON_Q,
		ST_ON_A,
		ST_ON_B,
		ST_MEET_1,
		ST_MEET_2,
		ST_MEET_3,
		ST_MEET_4,
		ST_DONE
	} edge_state_t;
endpackage
`default_nettype wire

>>> hdl/pip_front.sv
// ----------------------------------------------------------------------------
// pip_front
// Accepts vertices, keeps polygon bookkeeping and queues edge jobs.
// ----------------------------------------------------------------------------
`default_nettype none
module pip_front import pip_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         push,
	output logic                        full,
	input  wire  signed [COORD_BITS-1:0] vertex_x,
	input  wire  signed [COORD_BITS-1:0] vertex_y,
	input  wire  signed [COORD_BITS-1:0] query_x,
	input  wire  signed [COORD_BITS-1:0] query_y,
	input  wire                         first_vertex,
	input  wire                         last_vertex,
	// job queue read side
	output logic                        job_valid,
	input  wire                         job_take,
	output logic [6*COORD_BITS+3-1:0]   job_data
);
	localparam int JW = 6*COORD_BITS + 3;
	// job: {qx, qy, ax, ay, bx, by, first, last, closing}
	logic [JW-1:0] q_q [QUEUE_DEPTH];
	logic [0:0] wp_q, rp_q;
	logic [1:0] cnt_q;
	logic signed [COORD_BITS-1:0] px_q, py_q, sx_q, sy_q, vx_q, vy_q;
	logic pend_q;
	logic signed [COORD_BITS-1:0] cqx, cqy;
	logic [JW-1:0] wdat;
	logic wr, rd, acc;

	assign cqx = first_vertex ? query_x : px_q;
	assign cqy = first_vertex ? query_y : py_q;
	assign acc = push && !full;
	assign rd  = job_take && job_valid;
	// closing edge is pushed the cycle after the last vertex
	assign wr = acc || pend_q;
	assign wdat = pend_q ? {px_q, py_q, vx_q, vy_q, sx_q, sy_q, 1'b0, 1'b1, 1'b1}
		: {cqx, cqy, vx_q, vy_q, vertex_x, vertex_y, first_vertex, last_vertex, 1'b0};
	assign full = pend_q || (cnt_q >= 2'(QUEUE_DEPTH - 1) && !rd) || cnt_q == 2'(QUEUE_DEPTH);
	assign job_valid = cnt_q != 2'd0;
	assign job_data = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			q_q[wp_q] <= wdat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0; pend_q <= 1'b0;
			px_q <= '0; py_q <= '0; sx_q <= '0; sy_q <= '0; vx_q <= '0; vy_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
			pend_q <= acc && last_vertex;
			if (acc) begin
				vx_q <= vertex_x;
				vy_q <= vertex_y;
				if (first_vertex) begin
					px_q <= query_x; py_q <= query_y;
					sx_q <= vertex_x; sy_q <= vertex_y;
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> hdl/pip_back.sv
// ----------------------------------------------------------------------------
// pip_back
// Edge tests on a shared multiplier; parity/boundary state; result register.
// ----------------------------------------------------------------------------
`default_nettype none
module pip_back import pip_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire  [CFG_IDX_BITS-1:0]    cfg_idx,
	input  wire  [CFG_BITS-1:0]        cfg_data,
	input  wire                        job_valid,
	output logic                       job_take,
	input  wire  [6*COORD_BITS+3-1:0]  job_data,
	output logic                       empty,
	input  wire                        pop,
	output logic [1:0]                 position
);
	localparam int CW = COORD_BITS;
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2*DW;
	localparam int XW = PW + 1;

	logic [AREA_TOL_BITS-1:0] atol_q;
	logic [LEVEL_TOL_BITS-1:0] ltol_q;
	edge_state_t st_q, st_d;
	logic signed [CW-1:0] qx_q, qy_q, ax_q, ay_q, bx_q, by_q;
	logic first_q, last_q, close_q;
	logic par_q, bnd_q;
	logic res_v_q;
	logic [1:0] res_q;
	logic hit_a_q, s1_q;
	logic signed [1:0] sg1_q;

	// cross operands for current step: (p1-p0)x(p2-p0)
	logic signed [CW-1:0] x0, y0, x1, y1, x2, y2;
	logic signed [DW-1:0] d1x, d1y, d2x, d2y;
	logic signed [PW-1:0] m1, m2;
	logic signed [XW-1:0] cr;
	logic [XW-1:0] acr;
	logic collinear;
	logic signed [1:0] sg;
	logic signed [CW-1:0] rx;

	assign rx = {1'b1, {(CW-1){1'b0}}};

	always_comb begin
		x0 = qx_q; y0 = qy_q; x1 = ax_q; y1 = ay_q; x2 = bx_q; y2 = by_q;
		case (st_q)
			ST_ON_Q:   begin x0 = qx_q; y0 = qy_q; x1 = ax_q; y1 = ay_q; x2 = bx_q; y2 = by_q; end
			ST_ON_A:   begin x0 = ax_q; y0 = ay_q; x1 = qx_q; y1 = qy_q; x2 = rx; y2 = qy_q; end
			ST_ON_B:   begin x0 = bx_q; y0 = by_q; x1 = qx_q; y1 = qy_q; x2 = rx; y2 = qy_q; end
			// segs_meet(q,r,a,b): a=q b=r c=A d=B
			ST_MEET_1: begin x0 = qx_q; y0 = qy_q; x1 = ax_q; y1 = ay_q; x2 = rx; y2 = qy_q; end
			ST_MEET_2: begin x0 = qx_q; y0 = qy_q; x1 = rx; y1 = qy_q; x2 = bx_q; y2 = by_q; end
			ST_MEET_3: begin x0 = ax_q; y0 = ay_q; x1 = qx_q; y1 = qy_q; x2 = bx_q; y2 = by_q; end
			ST_MEET_4: begin x0 = ax_q; y0 = ay_q; x1 = bx_q; y1 = by_q; x2 = rx; y2 = qy_q; end
			default: ;
		endcase
		d1x = DW'(x1) - DW'(x0);
		d1y = DW'(y1) - DW'(y0);
		d2x = DW'(x2) - DW'(x0);
		d2y = DW'(y2) - DW'(y0);
		m1 = PW'(d1x) * PW'(d2y);
		m2 = PW'(d2x) * PW'(d1y);
		cr = XW'(m1) - XW'(m2);
		acr = cr[XW-1] ? XW'(-cr) : XW'(cr);
		collinear = (XW > AREA_TOL_BITS) ? (acr <= XW'(atol_q))
			: (AREA_TOL_BITS'(acr) <= atol_q);
		sg = cr[XW-1] ? -2'sd1 : (cr != '0 ? 2'sd1 : 2'sd0);
	end

	// box tests
	function automatic logic between(input logic signed [CW-1:0] p,
		input logic signed [CW-1:0] u, input logic signed [CW-1:0] v);
		between = (p >= u && p <= v) || (p >= v && p <= u);
	endfunction

	logic on_q_box, on_a_box, on_b_box, horiz, meet_box;
	logic signed [CW:0] dyv;
	logic [CW:0] ady;
	always_comb begin
		on_q_box = between(qx_q, ax_q, bx_q) && between(qy_q, ay_q, by_q);
		on_a_box = between(ax_q, qx_q, rx) && (ay_q == qy_q);
		on_b_box = between(bx_q, qx_q, rx) && (by_q == qy_q);
		dyv = (CW+1)'(ay_q) - (CW+1)'(by_q);
		ady = dyv[CW] ? (CW+1)'(-dyv) : (CW+1)'(dyv);
		horiz = (CW+1 > LEVEL_TOL_BITS) ? (ady <= (CW+1)'(ltol_q))
			: (LEVEL_TOL_BITS'(ady) <= ltol_q);
		// ray spans [rx,qx] at qy
		meet_box = !((qx_q < (ax_q < bx_q ? ax_q : bx_q)) || ((ax_q > bx_q ? ax_q : bx_q) < rx))
			&& !((qy_q < (ay_q < by_q ? ay_q : by_q)) || ((ay_q > by_q ? ay_q : by_q) < qy_q));
	end

	assign job_take = (st_q == ST_IDLE);
	assign empty = !res_v_q;
	assign position = res_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:   if (job_valid) st_d = ST_LOAD;
			ST_LOAD:   st_d = first_q ? ST_IDLE : ST_ON_Q;
			ST_ON_Q:   st_d = horiz ? ST_DONE : ST_ON_A;
			ST_ON_A:   st_d = ST_ON_B;
			ST_ON_B:   st_d = (hit_a_q || (collinear && on_b_box)) ? ST_DONE : ST_MEET_1;
			ST_MEET_1: st_d = ST_MEET_2;
			ST_MEET_2: st_d = ST_MEET_3;
			ST_MEET_3: st_d = ST_MEET_4;
			ST_MEET_4: st_d = ST_DONE;
			// closing edge waits here while the previous result is still held
			ST_DONE:   st_d = (close_q && res_v_q) ? ST_DONE : ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; atol_q <= '0; ltol_q <= '0;
			par_q <= 1'b0; bnd_q <= 1'b0; res_v_q <= 1'b0; res_q <= '0;
			qx_q <= '0; qy_q <= '0; ax_q <= '0; ay_q <= '0; bx_q <= '0; by_q <= '0;
			first_q <= 1'b0; last_q <= 1'b0; close_q <= 1'b0;
			hit_a_q <= 1'b0; s1_q <= 1'b0; sg1_q <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				case (cfg_idx)
					REG_AREA_TOL:  atol_q <= cfg_data[AREA_TOL_BITS-1:0];
					REG_LEVEL_TOL: ltol_q <= cfg_data[LEVEL_TOL_BITS-1:0];
					default: ;
				endcase
			end
			if (pop && res_v_q) res_v_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (job_valid) begin
					{qx_q, qy_q, ax_q, ay_q, bx_q, by_q, first_q, last_q, close_q} <= job_data;
				end
				ST_LOAD: if (first_q) begin
					par_q <= 1'b0; bnd_q <= 1'b0;
				end
				ST_ON_Q: if (collinear && on_q_box) bnd_q <= 1'b1;
				ST_ON_A: begin
					hit_a_q <= collinear && on_a_box;
					if (collinear && on_a_box && ay_q > by_q) par_q <= ~par_q;
				end
				ST_ON_B: if (!hit_a_q && collinear && on_b_box && by_q > ay_q) par_q <= ~par_q;
				ST_MEET_1: sg1_q <= sg;
				ST_MEET_2: s1_q <= (sg1_q * sg) < 0;
				ST_MEET_3: sg1_q <= sg;
				ST_MEET_4: if (meet_box && !s1_q && (sg1_q * sg) >= 0) par_q <= ~par_q;
				ST_DONE: if (last_q && close_q && !res_v_q) begin
					res_v_q <= 1'b1;
					res_q <= bnd_q ? POS_BOUNDARY : (par_q ? POS_INSIDE : POS_OUTSIDE);
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hdl/point_in_polygon_ray_cast_top.sv
// ----------------------------------------------------------------------------
// point_in_polygon_ray_cast_top
// Vertices queue as edge jobs while the back end is busy; 7 products on one unit.
// Reset: arst_n clears polygon state, tolerances, the job queue and the result.
// ----------------------------------------------------------------------------
`default_nettype none
module point_in_polygon_ray_cast_top import pip_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         push,
	output logic                        full,
	input  wire  signed [COORD_BITS-1:0] vertex_x,
	input  wire  signed [COORD_BITS-1:0] vertex_y,
	input  wire  signed [COORD_BITS-1:0] query_x,
	input  wire  signed [COORD_BITS-1:0] query_y,
	input  wire                         first_vertex,
	input  wire                         last_vertex,
	output logic                        empty,
	input  wire                         pop,
	output logic [1:0]                  position,
	input  wire                         cfg_we,
	input  wire  [CFG_IDX_BITS-1:0]     cfg_idx,
	input  wire  [CFG_BITS-1:0]         cfg_data
);
	logic job_valid, job_take;
	logic [6*COORD_BITS+3-1:0] job_data;

	pip_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk, .arst_n, .push, .full, .vertex_x, .vertex_y, .query_x, .query_y,
		.first_vertex, .last_vertex, .job_valid, .job_take, .job_data
	);

	pip_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data, .job_valid, .job_take,
		.job_data, .empty, .pop, .position
	);
endmodule
`default_nettype wire
